/* hw/rtl/fcs_pkg.sv */
`timescale 1ns / 1ps

package fcs_pkg;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SUM8  = 2'd1;
  localparam logic [1:0] MODE_XOR8  = 2'd2;
  localparam logic [1:0] MODE_CRC16 = 2'd3;

  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_BYTE = 2'd1;
  localparam logic [1:0] LEN_CRC  = 2'd2;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  typedef struct packed {
    logic [15:0] check;
    logic [1:0]  length;
  } upd_t;

  function automatic logic [15:0] start_value(input logic [1:0] mode);
    return (mode == MODE_CRC16) ? CRC_START : 16'h0000;
  endfunction

  // reflected crc, one bit per step, eight steps per word
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/fcs_if.sv */
`timescale 1ns / 1ps

interface fcs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface fcs_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] check_value;
  logic [1:0]  check_length;
  modport source(output valid, output check_value, output check_length, input ready);
  modport sink(input valid, input check_value, input check_length, output ready);
endinterface

interface fcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] check_mode;
  modport source(output valid, output check_mode, input ready);
  modport sink(input valid, input check_mode, output ready);
endinterface

/* hw/rtl/fcs_update.sv */
`timescale 1ns / 1ps

module fcs_update (
  input  logic [1:0]    mode,
  input  logic [15:0]   running,
  input  logic [7:0]    data_byte,
  output fcs_pkg::upd_t upd
);
  import fcs_pkg::*;

  always_comb begin
    case (mode)
      MODE_SUM8: begin
        upd.check  = {8'h00, running[7:0] + data_byte};
        upd.length = LEN_BYTE;
      end
      MODE_XOR8: begin
        upd.check  = {8'h00, running[7:0] ^ data_byte};
        upd.length = LEN_BYTE;
      end
      MODE_CRC16: begin
        upd.check  = crc_byte(running, data_byte);
        upd.length = LEN_CRC;
      end
      default: begin
        upd.check  = 16'h0000;
        upd.length = LEN_NONE;
      end
    endcase
  end

endmodule

/* hw/rtl/frame_check_sum_xor_crc16.sv */
`timescale 1ns / 1ps

// Frame check generator: one frame word per cycle, last word flagged. Each
// accepted word is held in an input register, then a single pass
// updates the running sum8, xor8 or CRC-16/Modbus value (eight unrolled
// shift steps); on the last word the check and its byte count go to the
// result register. Sustained rate is one word per cycle, and a last word
// passes the input register and then the result register; the input register
// only stalls when a last word meets a result not yet taken. A mode write
// (always ready) reloads the running value with that mode's start value.
module frame_check_sum_xor_crc16 (
  input logic          clk,
  input logic          rst,
  fcs_byte_if.sink     frame,
  fcs_cfg_if.sink      cfg,
  fcs_result_if.source result
);
  import fcs_pkg::*;

  logic [1:0]  mode;
  logic [15:0] running;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;

  logic        out_valid;
  logic [15:0] out_value;
  logic [1:0]  out_length;

  upd_t        upd;
  logic        s1_fire;
  logic        cfg_fire;

  fcs_update u_update (
    .mode      (mode),
    .running   (running),
    .data_byte (s1_byte),
    .upd       (upd)
  );

  // a non-last word never needs the result slot
  assign s1_fire   = s1_valid && (!s1_last || !out_valid || result.ready);
  assign frame.ready = !s1_valid || s1_fire;
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  assign result.valid        = out_valid;
  assign result.check_value  = out_value;
  assign result.check_length = out_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
    if (frame.valid && frame.ready) begin
      s1_byte <= frame.data_byte;
      s1_last <= frame.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NONE;
      running <= start_value(MODE_NONE);
    end else if (cfg_fire) begin
      mode    <= cfg.check_mode;
      running <= start_value(cfg.check_mode);
    end else if (s1_fire) begin
      running <= s1_last ? start_value(mode) : upd.check;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      out_value  <= upd.check;
      out_length <= upd.length;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> running == start_value(mode))
    else $error("running value not restarted after last word");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && out_valid && !result.ready |=> s1_valid && s1_last)
    else $error("last word dropped while result pending");

  a_narrow_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_length != LEN_CRC |-> out_value[15:8] == 8'h00)
    else $error("8-bit check has high byte set");

  a_cfg_load: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> running == start_value(mode))
    else $error("mode write did not load start value");

endmodule
